### src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, control word layout and the microprogram of the sequential
// list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

  // Field widths and defaults
  localparam int CAPACITY_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int POS_W        = 8;
  localparam int CNT_W        = 8;
  localparam int STAT_W       = 2;
  localparam int FIDX_W       = 7;
  localparam int LEN_W        = 8;
  localparam int UPC_W        = 5;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND, OP_READ, OP_INSERT, OP_DELETE,
    OP_LOCATE, OP_PRIOR, OP_NEXT, OP_CLEAR
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK, ST_MISS, ST_FULL
  } status_t;

  // Branch conditions
  typedef enum logic [4:0] {
    C_NONE, C_DISPATCH, C_OUT_FREE, C_FULL, C_POS_GE_USED, C_POS_GT_USED,
    C_POS_EQ_USED, C_DEL_BAD, C_DEL_NONE, C_PTR_EQ_POS1, C_SP_EQ_USED,
    C_STOP, C_MATCH, C_OP_LOCATE, C_OP_PRIOR, C_PTR_ZERO, C_LAST, C_USED_ZERO
  } cond_t;

  // Read address select
  typedef enum logic [2:0] {
    RA_POS, RA_USED_M1, RA_PTR_M2, RA_POS_CNT, RA_SP, RA_ZERO, RA_PTR_P1,
    RA_PTR_M1
  } ra_t;

  typedef enum logic [1:0] {WA_PTR, WA_USED, WA_POS} wa_t;
  typedef enum logic {WD_RDATA, WD_VALUE} wd_t;

  typedef enum logic [2:0] {
    P_HOLD, P_LOAD_USED, P_LOAD_POS, P_LOAD_ZERO, P_DEC, P_INC
  } ptr_op_t;

  typedef enum logic [1:0] {S_HOLD, S_LOAD_POS_CNT1, S_INC} sp_op_t;
  typedef enum logic [1:0] {U_HOLD, U_INC, U_SUB_CNT, U_CLEAR} used_op_t;
  typedef enum logic [1:0] {SS_NONE, SS_MISS, SS_FULL} set_st_t;

  // One control word per microstep
  typedef struct packed {
    cond_t    cond;
    upc_t     jt;        // target when condition holds
    upc_t     nt;        // target otherwise
    logic     squash;    // drop datapath actions when the branch is taken
    logic     we;
    wa_t      wa;
    wd_t      wd;
    logic     re;
    ra_t      ra;
    ptr_op_t  ptr_op;
    sp_op_t   sp_op;
    used_op_t used_op;
    set_st_t  set_st;
    logic     load_data;
    logic     load_fidx;
    logic     load_out;
  } ctrl_t;

  // Datapath status toward the sequencer
  typedef struct packed {
    logic full;
    logic pos_ge_used;
    logic pos_gt_used;
    logic pos_eq_used;
    logic del_bad;
    logic del_none;
    logic ptr_eq_pos1;
    logic sp_eq_used;
    logic stop;
    logic match;
    logic op_locate;
    logic op_prior;
    logic ptr_zero;
    logic last;
    logic used_zero;
  } flags_t;

  // Microprogram addresses
  localparam upc_t A_FETCH     = 5'd0;
  localparam upc_t A_RESULT    = 5'd1;
  localparam upc_t A_MISS      = 5'd2;
  localparam upc_t A_FULL      = 5'd3;
  localparam upc_t A_APPEND    = 5'd4;
  localparam upc_t A_READ      = 5'd5;
  localparam upc_t A_LOAD      = 5'd6;
  localparam upc_t A_INS       = 5'd7;
  localparam upc_t A_INS_CHK   = 5'd8;
  localparam upc_t A_INS_EQ    = 5'd9;
  localparam upc_t A_INS_LOOP  = 5'd10;
  localparam upc_t A_INS_PUT   = 5'd11;
  localparam upc_t A_DEL       = 5'd12;
  localparam upc_t A_DEL_CHK   = 5'd13;
  localparam upc_t A_DEL_LOOP  = 5'd14;
  localparam upc_t A_DEL_END   = 5'd15;
  localparam upc_t A_SRCH      = 5'd16;
  localparam upc_t A_SRCH_LOOP = 5'd17;
  localparam upc_t A_SRCH_END  = 5'd18;
  localparam upc_t A_SRCH_OP   = 5'd19;
  localparam upc_t A_SRCH_OP2  = 5'd20;
  localparam upc_t A_LOC       = 5'd21;
  localparam upc_t A_PRIOR     = 5'd22;
  localparam upc_t A_NEXT      = 5'd23;
  localparam upc_t A_CLEAR     = 5'd24;
  localparam upc_t A_LAST      = 5'd24;

  // Entry point of each request's program
  function automatic upc_t entry_of(opcode_t op);
    upc_t a;
    case (op)
      OP_APPEND: a = A_APPEND;
      OP_READ:   a = A_READ;
      OP_INSERT: a = A_INS;
      OP_DELETE: a = A_DEL;
      OP_LOCATE: a = A_SRCH;
      OP_PRIOR:  a = A_SRCH;
      OP_NEXT:   a = A_SRCH;
      OP_CLEAR:  a = A_CLEAR;
      default:   a = A_FETCH;
    endcase
    return a;
  endfunction

  // Control store
  function automatic ctrl_t ucode(upc_t a);
    ctrl_t w;
    w = '0;
    case (a)
      A_FETCH: begin
        w.cond = C_DISPATCH;
        w.nt   = A_FETCH;
      end
      A_RESULT: begin
        w.cond     = C_OUT_FREE;
        w.jt       = A_FETCH;
        w.nt       = A_RESULT;
        w.load_out = 1'b1;
      end
      A_MISS: begin
        w.set_st = SS_MISS;
        w.nt     = A_RESULT;
      end
      A_FULL: begin
        w.set_st = SS_FULL;
        w.nt     = A_RESULT;
      end
      A_APPEND: begin
        w.cond    = C_FULL;
        w.jt      = A_FULL;
        w.nt      = A_RESULT;
        w.squash  = 1'b1;
        w.we      = 1'b1;
        w.wa      = WA_USED;
        w.wd      = WD_VALUE;
        w.used_op = U_INC;
      end
      A_READ: begin
        w.cond   = C_POS_GE_USED;
        w.jt     = A_MISS;
        w.nt     = A_LOAD;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_POS;
      end
      A_LOAD: begin
        w.load_data = 1'b1;
        w.nt        = A_RESULT;
      end
      A_INS: begin
        w.cond = C_POS_GT_USED;
        w.jt   = A_MISS;
        w.nt   = A_INS_CHK;
      end
      A_INS_CHK: begin
        w.cond   = C_FULL;
        w.jt     = A_FULL;
        w.nt     = A_INS_EQ;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_USED_M1;
        w.ptr_op = P_LOAD_USED;
      end
      A_INS_EQ: begin
        w.cond = C_POS_EQ_USED;
        w.jt   = A_INS_PUT;
        w.nt   = A_INS_LOOP;
      end
      A_INS_LOOP: begin
        // move one entry up, fetch the one below it
        w.cond   = C_PTR_EQ_POS1;
        w.jt     = A_INS_PUT;
        w.nt     = A_INS_LOOP;
        w.we     = 1'b1;
        w.wa     = WA_PTR;
        w.wd     = WD_RDATA;
        w.re     = 1'b1;
        w.ra     = RA_PTR_M2;
        w.ptr_op = P_DEC;
      end
      A_INS_PUT: begin
        w.we      = 1'b1;
        w.wa      = WA_POS;
        w.wd      = WD_VALUE;
        w.used_op = U_INC;
        w.nt      = A_RESULT;
      end
      A_DEL: begin
        w.cond   = C_DEL_BAD;
        w.jt     = A_MISS;
        w.nt     = A_DEL_CHK;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_POS_CNT;
        w.ptr_op = P_LOAD_POS;
        w.sp_op  = S_LOAD_POS_CNT1;
      end
      A_DEL_CHK: begin
        w.cond = C_DEL_NONE;
        w.jt   = A_DEL_END;
        w.nt   = A_DEL_LOOP;
      end
      A_DEL_LOOP: begin
        // move one entry down by count, fetch the next source
        w.cond   = C_SP_EQ_USED;
        w.jt     = A_DEL_END;
        w.nt     = A_DEL_LOOP;
        w.we     = 1'b1;
        w.wa     = WA_PTR;
        w.wd     = WD_RDATA;
        w.re     = 1'b1;
        w.ra     = RA_SP;
        w.sp_op  = S_INC;
        w.ptr_op = P_INC;
      end
      A_DEL_END: begin
        w.used_op = U_SUB_CNT;
        w.nt      = A_RESULT;
      end
      A_SRCH: begin
        w.cond   = C_USED_ZERO;
        w.jt     = A_MISS;
        w.nt     = A_SRCH_LOOP;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_ZERO;
        w.ptr_op = P_LOAD_ZERO;
      end
      A_SRCH_LOOP: begin
        // compare current entry, prefetch the next one
        w.cond   = C_STOP;
        w.jt     = A_SRCH_END;
        w.nt     = A_SRCH_LOOP;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_PTR_P1;
        w.ptr_op = P_INC;
      end
      A_SRCH_END: begin
        w.cond = C_MATCH;
        w.jt   = A_SRCH_OP;
        w.nt   = A_MISS;
      end
      A_SRCH_OP: begin
        w.cond = C_OP_LOCATE;
        w.jt   = A_LOC;
        w.nt   = A_SRCH_OP2;
      end
      A_SRCH_OP2: begin
        w.cond = C_OP_PRIOR;
        w.jt   = A_PRIOR;
        w.nt   = A_NEXT;
      end
      A_LOC: begin
        w.load_fidx = 1'b1;
        w.nt        = A_RESULT;
      end
      A_PRIOR: begin
        w.cond   = C_PTR_ZERO;
        w.jt     = A_MISS;
        w.nt     = A_LOAD;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_PTR_M1;
      end
      A_NEXT: begin
        w.cond   = C_LAST;
        w.jt     = A_MISS;
        w.nt     = A_LOAD;
        w.squash = 1'b1;
        w.re     = 1'b1;
        w.ra     = RA_PTR_P1;
      end
      A_CLEAR: begin
        w.used_op = U_CLEAR;
        w.nt      = A_RESULT;
      end
      default: begin
        w.nt = A_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

### src/sequential_list_engine_top.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_top
// Fixed-capacity ordered list of signed words run by a microcoded sequencer.
// Requests are run one at a time, with a fetch step between requests; insert,
//   delete and the searches walk the store one entry per cycle, and a result
//   that out_ready holds off keeps the engine in its result step.
// Reset: length clears at once, store contents are left as they are, and a
//   request is taken in the first cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sequential_list_engine_top #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sle_pkg::OP_W-1:0]    opcode,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic [sle_pkg::CNT_W-1:0]   count,
  input  logic signed [sle_pkg::DATA_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sle_pkg::STAT_W-1:0]  status,
  output logic signed [sle_pkg::DATA_W-1:0] data,
  output logic [sle_pkg::FIDX_W-1:0]  found_index,
  output logic [sle_pkg::LEN_W-1:0]   list_length
);
  import sle_pkg::*;

  ctrl_t             cw;
  flags_t            flags;
  logic              in_beat;
  logic              out_free;
  logic              out_load;
  status_t           res_status;
  logic [DATA_W-1:0] res_data;
  logic [FIDX_W-1:0] res_fidx;
  logic [LEN_W-1:0]  res_len;

  // Handshake
  assign in_ready = (cw.cond == C_DISPATCH);
  assign in_beat  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign out_load = cw.load_out && out_free;

  sle_useq u_useq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .opcode   (opcode),
    .flags    (flags),
    .cw       (cw)
  );

  sle_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cw         (cw),
    .in_beat    (in_beat),
    .opcode     (opcode),
    .position   (position),
    .count      (count),
    .value      (value),
    .flags      (flags),
    .res_status (res_status),
    .res_data   (res_data),
    .res_fidx   (res_fidx),
    .res_len    (res_len)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      data        <= res_data;
      found_index <= res_fidx;
      list_length <= res_len;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> !in_ready)
    else $error("request taken while the previous one is still running");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_MISS || status == ST_FULL))
    else $error("undefined status on result");

endmodule

### src/sle_useq.sv
// ----------------------------------------------------------------------------
// sle_useq
// Microsequencer: step counter, control store lookup and branch selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_useq (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     out_free,
  input  logic [sle_pkg::OP_W-1:0] opcode,
  input  sle_pkg::flags_t          flags,
  output sle_pkg::ctrl_t           cw
);
  import sle_pkg::*;

  upc_t  upc;
  upc_t  upc_next;
  ctrl_t word;
  logic  taken;

  // Control store read
  assign word = ucode(upc);

  // Branch condition select
  always_comb begin
    case (word.cond)
      C_NONE:        taken = 1'b0;
      C_DISPATCH:    taken = in_valid;
      C_OUT_FREE:    taken = out_free;
      C_FULL:        taken = flags.full;
      C_POS_GE_USED: taken = flags.pos_ge_used;
      C_POS_GT_USED: taken = flags.pos_gt_used;
      C_POS_EQ_USED: taken = flags.pos_eq_used;
      C_DEL_BAD:     taken = flags.del_bad;
      C_DEL_NONE:    taken = flags.del_none;
      C_PTR_EQ_POS1: taken = flags.ptr_eq_pos1;
      C_SP_EQ_USED:  taken = flags.sp_eq_used;
      C_STOP:        taken = flags.stop;
      C_MATCH:       taken = flags.match;
      C_OP_LOCATE:   taken = flags.op_locate;
      C_OP_PRIOR:    taken = flags.op_prior;
      C_PTR_ZERO:    taken = flags.ptr_zero;
      C_LAST:        taken = flags.last;
      C_USED_ZERO:   taken = flags.used_zero;
      default:       taken = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (word.cond == C_DISPATCH) begin
      upc_next = in_valid ? entry_of(opcode_t'(opcode)) : word.nt;
    end else begin
      upc_next = taken ? word.jt : word.nt;
    end
  end

  // Squashed steps drop their datapath actions
  always_comb begin
    cw = word;
    if (word.squash && taken) begin
      cw.we        = 1'b0;
      cw.re        = 1'b0;
      cw.ptr_op    = P_HOLD;
      cw.sp_op     = S_HOLD;
      cw.used_op   = U_HOLD;
      cw.set_st    = SS_NONE;
      cw.load_data = 1'b0;
      cw.load_fidx = 1'b0;
    end
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  a_upc_in_program: assert property (@(posedge clk) disable iff (rst)
    upc <= A_LAST)
    else $error("step counter outside the microprogram");

endmodule

### src/sle_dpath.sv
// ----------------------------------------------------------------------------
// sle_dpath
// List datapath: entry store, request latches, pointers, length and the
// working result registers, driven by the control word and the request beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_dpath #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sle_pkg::ctrl_t              cw,
  input  logic                        in_beat,
  input  logic [sle_pkg::OP_W-1:0]    opcode,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic [sle_pkg::CNT_W-1:0]   count,
  input  logic [sle_pkg::DATA_W-1:0]  value,
  output sle_pkg::flags_t             flags,
  output sle_pkg::status_t            res_status,
  output logic [sle_pkg::DATA_W-1:0]  res_data,
  output logic [sle_pkg::FIDX_W-1:0]  res_fidx,
  output logic [sle_pkg::LEN_W-1:0]   res_len
);
  import sle_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W + 1) ? CW : POS_W + 1;
  localparam int PW = XW + 1;

  // Request latches
  opcode_t           op_q;
  logic [POS_W-1:0]  pos_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] val_q;

  // Pointers and length
  logic [CW-1:0] used;
  logic [CW-1:0] ptr;
  logic [CW-1:0] sp;

  // Store
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     wa;
  logic [DATA_W-1:0] wd;

  // Working result
  status_t           st;
  logic [DATA_W-1:0] dat;
  logic [FIDX_W-1:0] fix;

  // Widened operands for compares
  logic [PW-1:0] used_x;
  logic [PW-1:0] ptr_x;
  logic [PW-1:0] sp_x;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] pc_x;

  assign used_x = PW'(used);
  assign ptr_x  = PW'(ptr);
  assign sp_x   = PW'(sp);
  assign pos_x  = PW'(pos_q);
  assign pc_x   = PW'(pos_q) + PW'(cnt_q);

  // Flags toward the sequencer
  always_comb begin
    flags.full        = (used_x >= PW'(CAPACITY));
    flags.pos_ge_used = (pos_x >= used_x);
    flags.pos_gt_used = (pos_x > used_x);
    flags.pos_eq_used = (pos_x == used_x);
    flags.del_bad     = (pc_x > used_x);
    flags.del_none    = (pc_x == used_x);
    flags.ptr_eq_pos1 = (ptr_x == pos_x + PW'(1));
    flags.sp_eq_used  = (sp_x == used_x);
    flags.match       = (rdata == val_q);
    flags.last        = (ptr_x + PW'(1) == used_x);
    flags.stop        = flags.match || flags.last;
    flags.op_locate   = (op_q == OP_LOCATE);
    flags.op_prior    = (op_q == OP_PRIOR);
    flags.ptr_zero    = (ptr == '0);
    flags.used_zero   = (used == '0);
  end

  // Read address select
  always_comb begin
    case (cw.ra)
      RA_POS:     ra = AW'(pos_q);
      RA_USED_M1: ra = AW'(used - CW'(1));
      RA_PTR_M2:  ra = AW'(ptr - CW'(2));
      RA_POS_CNT: ra = AW'(pc_x);
      RA_SP:      ra = AW'(sp);
      RA_ZERO:    ra = '0;
      RA_PTR_P1:  ra = AW'(ptr + CW'(1));
      RA_PTR_M1:  ra = AW'(ptr - CW'(1));
      default:    ra = '0;
    endcase
  end

  // Write address and data select
  always_comb begin
    case (cw.wa)
      WA_PTR:  wa = AW'(ptr);
      WA_USED: wa = AW'(used);
      WA_POS:  wa = AW'(pos_q);
      default: wa = '0;
    endcase
    wd = (cw.wd == WD_VALUE) ? val_q : rdata;
  end

  // Entry store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cw.we) begin
      mem[wa] <= wd;
    end
    if (cw.re) begin
      rdata <= mem[ra];
    end
  end

  // Request latches
  always_ff @(posedge clk) begin
    if (in_beat) begin
      op_q  <= opcode_t'(opcode);
      pos_q <= position;
      cnt_q <= count;
      val_q <= value;
    end
  end

  // Walk pointers
  always_ff @(posedge clk) begin
    case (cw.ptr_op)
      P_LOAD_USED: ptr <= used;
      P_LOAD_POS:  ptr <= CW'(pos_q);
      P_LOAD_ZERO: ptr <= '0;
      P_DEC:       ptr <= ptr - CW'(1);
      P_INC:       ptr <= ptr + CW'(1);
      default:     ptr <= ptr;
    endcase
    case (cw.sp_op)
      S_LOAD_POS_CNT1: sp <= CW'(pc_x + PW'(1));
      S_INC:           sp <= sp + CW'(1);
      default:         sp <= sp;
    endcase
  end

  // List length
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      case (cw.used_op)
        U_INC:     used <= used + CW'(1);
        U_SUB_CNT: used <= used - CW'(cnt_q);
        U_CLEAR:   used <= '0;
        default:   used <= used;
      endcase
    end
  end

  // Working result, cleared when a request is taken
  always_ff @(posedge clk) begin
    if (in_beat) begin
      st  <= ST_OK;
      dat <= '0;
      fix <= '0;
    end else begin
      case (cw.set_st)
        SS_MISS: st <= ST_MISS;
        SS_FULL: st <= ST_FULL;
        default: st <= st;
      endcase
      if (cw.load_data) begin
        dat <= rdata;
      end
      if (cw.load_fidx) begin
        fix <= FIDX_W'(ptr);
      end
    end
  end

  assign res_status = st;
  assign res_data   = dat;
  assign res_fidx   = fix;
  assign res_len    = LEN_W'(used);

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_x <= PW'(CAPACITY))
    else $error("list length above capacity");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (rst)
    in_beat |-> (!cw.we && cw.used_op == U_HOLD))
    else $error("store or length changed while taking a request");

endmodule

### tb/sle_list_checker.sv
// ----------------------------------------------------------------------------
// sle_list_checker
// Watches both channels of the sequential list engine. Every request beat
// is run through a local model of the list; every result beat is compared
// field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_list_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [sle_pkg::OP_W-1:0]          opcode,
  input  logic [sle_pkg::POS_W-1:0]         position,
  input  logic [sle_pkg::CNT_W-1:0]         count,
  input  logic signed [sle_pkg::DATA_W-1:0] value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [sle_pkg::STAT_W-1:0]        status,
  input  logic signed [sle_pkg::DATA_W-1:0] data,
  input  logic [sle_pkg::FIDX_W-1:0]        found_index,
  input  logic [sle_pkg::LEN_W-1:0]         list_length,
  output int                                fail_count,
  output int                                waiting
);
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;

  typedef struct packed {
    status_t           st;
    logic [DATA_W-1:0] data;
    logic [FIDX_W-1:0] fidx;
    logic [LEN_W-1:0]  len;
  } list_result_t;

  // Local copy of the list
  logic [DATA_W-1:0] store [CAP];
  int                depth;

  list_result_t result_q [$];
  int           errs = 0;

  // Apply one request to the local list and return the result it gives
  function automatic list_result_t apply_request(opcode_t op, int pos, int cnt,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    int           hit;
    int           i;
    r.st   = ST_OK;
    r.data = '0;
    r.fidx = '0;
    // first match, or depth when there is none
    hit = depth;
    for (i = depth - 1; i >= 0; i--) begin
      if (store[i] == val) hit = i;
    end
    case (op)
      OP_APPEND: begin
        if (depth >= CAP) begin
          r.st = ST_FULL;
        end else begin
          store[depth] = val;
          depth++;
        end
      end
      OP_READ: begin
        if (pos < depth) r.data = store[pos];
        else r.st = ST_MISS;
      end
      OP_INSERT: begin
        // position range is checked before fullness
        if (pos > depth) begin
          r.st = ST_MISS;
        end else if (depth >= CAP) begin
          r.st = ST_FULL;
        end else begin
          for (i = depth; i > pos; i--) store[i] = store[i-1];
          store[pos] = val;
          depth++;
        end
      end
      OP_DELETE: begin
        if (pos + cnt > depth) begin
          r.st = ST_MISS;
        end else begin
          for (i = pos; i + cnt < depth; i++) store[i] = store[i+cnt];
          depth -= cnt;
        end
      end
      OP_LOCATE: begin
        if (hit < depth) r.fidx = FIDX_W'(hit);
        else r.st = ST_MISS;
      end
      OP_PRIOR: begin
        if (hit < depth && hit > 0) r.data = store[hit-1];
        else r.st = ST_MISS;
      end
      OP_NEXT: begin
        if (hit + 1 < depth) r.data = store[hit+1];
        else r.st = ST_MISS;
      end
      default: begin
        depth = 0;
      end
    endcase
    r.len = LEN_W'(depth);
    return r;
  endfunction

  // Predict on request beats, compare on result beats
  always @(posedge clk) begin : monitor
    list_result_t exp_r;
    list_result_t pred_r;
    if (rst) begin
      depth = 0;
      result_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        pred_r = apply_request(opcode_t'(opcode), int'(position),
                               int'(count), value);
        result_q = {result_q, pred_r};
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result beat with no request pending: status %0d data %08h",
                 status, data);
          errs++;
        end else begin
          exp_r = result_q.pop_front();
          if (status !== exp_r.st) begin
            $error("status: expected %0d, got %0d", exp_r.st, status);
            errs++;
          end
          if (data !== exp_r.data) begin
            $error("data: expected %08h, got %08h", exp_r.data, data);
            errs++;
          end
          if (found_index !== exp_r.fidx) begin
            $error("found_index: expected %0d, got %0d", exp_r.fidx, found_index);
            errs++;
          end
          if (list_length !== exp_r.len) begin
            $error("list_length: expected %0d, got %0d", exp_r.len, list_length);
            errs++;
          end
        end
      end
    end
    fail_count <= errs;
    waiting    <= result_q.size();
  end

endmodule

### tb/tb_sequential_list_engine_top.sv
// ----------------------------------------------------------------------------
// tb_sequential_list_engine_top
// Drives the sequential list engine with a directed opening and then phased
// random traffic (growing to capacity, mixed, shrinking) with random idle
// cycles on both sides; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sequential_list_engine_top;
  import sle_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1925;
  localparam int PHASE_LEN      = 120;
  localparam int MAX_INDEX      = 128;
  localparam int POOL_SIZE      = 8;
  localparam int IDLE_PCT       = 22;
  localparam int RX_HOLD_CYCLES = 500;
  localparam int HOLD_AT_ITEM   = 400;
  localparam int DRAIN_AT_ITEM  = 1000;
  localparam int CALM_FIRST     = 1300;
  localparam int CALM_LAST      = 1600;
  localparam int TAIL_CYCLES    = 200;
  localparam int TIMEOUT_NS     = 30_000_000;

  typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid;
  logic                     in_ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] value;
  logic                     out_valid;
  logic                     out_ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] data;
  logic [FIDX_W-1:0]        found_index;
  logic [LEN_W-1:0]         list_length;

  int fails;
  int waiting;

  // Stimulus shaping state
  int                len_hint = 0;
  int                longest  = 0;
  int                op_tally [8];
  int                sent     = 0;
  bit                calm      = 1'b0;
  bit                hold_req  = 1'b0;
  bit                hold_done = 1'b0;
  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  always #10 clk = ~clk;

  sequential_list_engine_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .count       (count),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .list_length (list_length)
  );

  sle_list_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .position    (position),
    .count       (count),
    .value       (value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .data        (data),
    .found_index (found_index),
    .list_length (list_length),
    .fail_count  (fails),
    .waiting     (waiting)
  );

  // Track the length the block reports, to aim positions at the live list
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      len_hint <= int'(list_length);
      if (int'(list_length) > longest) longest <= int'(list_length);
    end
  end

  // Result side: random stalls, one long counted hold-off
  initial begin : result_sink
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offer one request beat and wait for it to be taken
  task automatic send_request(input opcode_t op, input int pos, input int cnt,
                              input logic [DATA_W-1:0] val);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    opcode   <= op;
    position <= POS_W'(pos);
    count    <= CNT_W'(cnt);
    value    <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    op_tally[op]++;
    sent++;
  endtask

  // Stop offering until every predicted result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  function automatic logic [DATA_W-1:0] fresh_value();
    logic [DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'hFFFF_FFFF;
      3:       v = 32'h0000_0000;
      4:       v = DATA_W'($urandom_range(15));
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly reuse pooled values so searches hit and duplicates appear
  function automatic logic [DATA_W-1:0] pick_value(bit for_store);
    logic [DATA_W-1:0] v;
    if ($urandom_range(99) < (for_store ? 50 : 20)) begin
      v = fresh_value();
      if (for_store) value_pool[$urandom_range(POOL_SIZE-1)] = v;
    end else begin
      v = value_pool[$urandom_range(POOL_SIZE-1)];
    end
    return v;
  endfunction

  function automatic opcode_t pick_op(phase_t ph);
    int r;
    opcode_t op;
    r = $urandom_range(99);
    case (ph)
      PH_GROW:
        op = (r < 45) ? OP_APPEND : (r < 70) ? OP_INSERT : (r < 78) ? OP_READ :
             (r < 84) ? OP_LOCATE : (r < 89) ? OP_PRIOR : (r < 94) ? OP_NEXT :
             OP_DELETE;
      PH_SHRINK:
        op = (r < 10) ? OP_APPEND : (r < 15) ? OP_INSERT : (r < 30) ? OP_READ :
             (r < 70) ? OP_DELETE : (r < 80) ? OP_LOCATE : (r < 90) ? OP_PRIOR :
             (r < 99) ? OP_NEXT : OP_CLEAR;
      default:
        op = (r < 15) ? OP_APPEND : (r < 30) ? OP_INSERT : (r < 45) ? OP_READ :
             (r < 60) ? OP_DELETE : (r < 73) ? OP_LOCATE : (r < 85) ? OP_PRIOR :
             (r < 98) ? OP_NEXT : OP_CLEAR;
    endcase
    return op;
  endfunction

  function automatic phase_t phase_for(int k);
    phase_t ph;
    case ((k / PHASE_LEN) % 5)
      0, 1:    ph = PH_GROW;
      3:       ph = PH_SHRINK;
      default: ph = PH_MIXED;
    endcase
    return ph;
  endfunction

  // One random request; unused fields carry random noise
  task automatic random_request(input phase_t ph);
    opcode_t           op;
    int                pos;
    int                cnt;
    int                room;
    int                r;
    logic [DATA_W-1:0] val;
    op  = pick_op(ph);
    pos = $urandom_range(MAX_INDEX);
    cnt = $urandom_range(MAX_INDEX);
    val = pick_value(op == OP_APPEND || op == OP_INSERT);
    r   = $urandom_range(99);
    case (op)
      OP_READ: begin
        if (len_hint > 0 && r < 85) pos = $urandom_range(len_hint - 1);
      end
      OP_INSERT: begin
        if (r < 85) pos = $urandom_range(len_hint);
      end
      OP_DELETE: begin
        pos  = $urandom_range(len_hint);
        room = len_hint - pos;
        if (r < 80) cnt = $urandom_range((room < 3) ? room : 3);
        else if (r < 90) cnt = $urandom_range(room);
        else if (r < 95) pos = $urandom_range(MAX_INDEX);
      end
      default: begin
      end
    endcase
    send_request(op, pos, cnt, val);
  endtask

  // Requests: directed opening, then phased random traffic
  initial begin : stimulus
    int k;
    in_valid <= 1'b0;
    opcode   <= OP_APPEND;
    position <= '0;
    count    <= '0;
    value    <= '0;
    for (k = 0; k < POOL_SIZE; k++) value_pool[k] = fresh_value();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // empty list: every lookup misses, empty delete is fine
    send_request(OP_READ,   0, 0, 32'h0);
    send_request(OP_LOCATE, 0, 0, 32'h0);
    send_request(OP_PRIOR,  0, 0, 32'h0);
    send_request(OP_NEXT,   0, 0, 32'h0);
    send_request(OP_DELETE, 0, 0, 32'h0);
    send_request(OP_DELETE, 0, 1, 32'h0);
    send_request(OP_INSERT, 1, 0, 32'h1);
    // build a short list with extreme values
    send_request(OP_INSERT, 0, 0, 32'h7FFF_FFFF);
    send_request(OP_APPEND, 0, 0, 32'h8000_0000);
    send_request(OP_APPEND, 0, 0, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 0, 0, 32'h0000_0000);
    send_request(OP_INSERT, 4, 0, 32'h0000_0005);
    send_request(OP_INSERT, 1, 0, 32'h1234_5678);
    // reads at both ends and past the end
    send_request(OP_READ,   0, 0, 32'h0);
    send_request(OP_READ,   5, 0, 32'h0);
    send_request(OP_READ,   6, 0, 32'h0);
    send_request(OP_READ,   MAX_INDEX, MAX_INDEX, 32'h0);
    // searches: hit, neighbor off either end, plain miss
    send_request(OP_LOCATE, 0, 0, 32'h8000_0000);
    send_request(OP_PRIOR,  0, 0, 32'h7FFF_FFFF);
    send_request(OP_NEXT,   0, 0, 32'h0000_0005);
    send_request(OP_PRIOR,  0, 0, 32'hFFFF_FFFF);
    send_request(OP_NEXT,   0, 0, 32'h7FFF_FFFF);
    send_request(OP_LOCATE, 0, 0, 32'h55AA_55AA);
    // delete runs, in range and past the end, then clear
    send_request(OP_DELETE, 1, 2, 32'h0);
    send_request(OP_DELETE, 2, MAX_INDEX, 32'h0);
    send_request(OP_CLEAR,  0, 0, 32'h0);
    wait_all_results();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == HOLD_AT_ITEM) hold_req = 1'b1;
      if (k == DRAIN_AT_ITEM) wait_all_results();
      calm = (k >= CALM_FIRST && k < CALM_LAST);
      random_request(phase_for(k));
    end
    calm = 1'b0;
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests: append %0d read %0d insert %0d delete %0d",
             sent, op_tally[OP_APPEND], op_tally[OP_READ], op_tally[OP_INSERT],
             op_tally[OP_DELETE]);
    $display("  locate %0d prior %0d next %0d clear %0d; longest list %0d",
             op_tally[OP_LOCATE], op_tally[OP_PRIOR], op_tally[OP_NEXT],
             op_tally[OP_CLEAR], longest);
    if (fails == 0 && waiting == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule
